FILE: sv/bfr_pkg.sv
// Shared types, constants and glyph table for the 5x7 text rasterizer.
package bfr_pkg;

    localparam int unsigned C_GLYPH_ROWS = 7;
    localparam int unsigned C_GLYPH_COLS = 5;
    localparam int unsigned C_GLYPH_BITS = C_GLYPH_ROWS * C_GLYPH_COLS;
    localparam int unsigned C_COORD_W    = 16;
    localparam int unsigned C_SCALE_W    = 5;
    localparam int unsigned C_OFS_W      = 8;
    localparam int unsigned C_COL_W      = 3;
    localparam int unsigned C_Q_DEPTH    = 2;
    localparam int unsigned C_Q_AW       = 1;
    localparam int unsigned C_Q_CW       = 2;

    localparam logic [C_SCALE_W-1:0] C_MAX_SCALE = 5'd16;
    localparam logic [C_SCALE_W-1:0] C_MIN_SCALE = 5'd1;
    localparam logic [C_COL_W-1:0]   C_LAST_COL  = 3'd4;

    typedef logic [C_GLYPH_BITS-1:0] t_glyph;
    typedef logic signed [C_COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
        t_coord     origin_x;
        t_coord     origin_y;
    } t_in_item;

    typedef struct packed {
        t_coord               rect_x;
        t_coord               rect_y;
        logic [C_SCALE_W-1:0] rect_size;
        logic                 last_dot;
    } t_out_item;

    typedef struct packed {
        t_glyph               bits;
        t_coord               base_x;
        t_coord               base_y;
        logic [C_SCALE_W-1:0] scale;
    } t_cmd;

    function automatic t_coord sat16(input logic signed [C_COORD_W:0] v);
        t_coord r;
        if (v[C_COORD_W] != v[C_COORD_W-1]) begin
            r = v[C_COORD_W] ? {1'b1, {(C_COORD_W-1){1'b0}}} : {1'b0, {(C_COORD_W-1){1'b1}}};
        end else begin
            r = v[C_COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_coord add_ofs(input t_coord base, input logic [C_OFS_W-1:0] ofs);
        logic signed [C_COORD_W:0] s;
        s = (C_COORD_W+1)'(base) + (C_COORD_W+1)'(signed'({1'b0, ofs}));
        return sat16(s);
    endfunction

    // Rows top to bottom, leftmost column in the high bit of each row.
    function automatic t_glyph glyph_bits(input logic [7:0] code);
        logic [7:0] c;
        t_glyph     g;
        c = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            c = code - 8'h20;
        end
        case (c)
            8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
            8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
            8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
            8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
            8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
            8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
            8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
            8'h49: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
            8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
            8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
            8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
            8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
            8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
            8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
            8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
            8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
            8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
            8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
            8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
            8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
            8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
            8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
            8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
            8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
            8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
            8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
            8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
            8'h33: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
            8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
            8'h35: g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
            8'h36: g = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
            8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
            8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
            8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
            8'h3A: g = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00};
            8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C};
            8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
            8'h2F: g = {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10};
            8'h3E: g = {5'h10,5'h08,5'h04,5'h02,5'h04,5'h08,5'h10};
            8'h3C: g = {5'h01,5'h02,5'h04,5'h08,5'h04,5'h02,5'h01};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

FILE: sv/bitmap_font_text_rasterizer.sv
// Top level of the 5x7 bitmap font text rasterizer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | push / full               | i_item   (t_in_item)
//  result   | pop / empty               | o_result (t_out_item)
//  config   | i_cfg_we (no wait)        | i_cfg_wdata (pixel scale)
//
// One character is accepted per cycle while the two-entry command queue has room.
// The scanner walks one glyph position per cycle, unless a waiting result is not
// popped, up to the last set dot; a queued character loads in the last dot's cycle,
// an idle scanner loads first. Blank characters and spaces take no scanner time.
// Reset is synchronous: scale 1, cursor and line at zero, queue and output empty.
// A low pop holds a waiting result register and the scanner; the queue then fills.
module bitmap_font_text_rasterizer import bfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [C_SCALE_W-1:0] i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    input  logic                 pop,
    output logic                 empty,
    output t_out_item            o_result
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    bfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_cmd       (front_cmd)
    );

    bfr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    bfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_q_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

FILE: sv/bfr_front.sv
// Front end: scale register, cursor tracking and glyph lookup into commands.
module bfr_front import bfr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [C_SCALE_W-1:0] i_cfg_wdata,
    input  logic                 i_push,
    input  t_in_item             i_item,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_q_push,
    output t_cmd                 o_cmd
);

    logic [C_SCALE_W-1:0] r_scale;
    t_coord               r_cursor_x;
    t_coord               r_line_y;
    t_coord               n_cursor_x;
    t_coord               n_line_y;
    logic [C_SCALE_W-1:0] eff_scale;
    logic [C_OFS_W-1:0]   advance;
    t_glyph               bits;
    t_coord               base_x;
    t_coord               base_y;
    logic                 accept;

    always_comb begin
        if (r_scale < C_MIN_SCALE) begin
            eff_scale = C_MIN_SCALE;
        end else if (r_scale > C_MAX_SCALE) begin
            eff_scale = C_MAX_SCALE;
        end else begin
            eff_scale = r_scale;
        end
    end

    assign accept  = i_push && !i_q_full;
    assign base_x  = i_item.string_start ? i_item.origin_x : r_cursor_x;
    assign base_y  = i_item.string_start ? i_item.origin_y : r_line_y;
    assign advance = C_OFS_W'({eff_scale, 2'b00}) + C_OFS_W'({eff_scale, 1'b0});
    assign bits    = glyph_bits(i_item.char_code);

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_line_y   = r_line_y;
        if (accept) begin
            n_cursor_x = add_ofs(base_x, advance);
            n_line_y   = base_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= C_MIN_SCALE;
            r_cursor_x <= '0;
            r_line_y   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            r_cursor_x <= n_cursor_x;
            r_line_y   <= n_line_y;
        end
    end

    // drop blank glyphs here: they only move the cursor
    assign o_q_push     = accept && (bits != '0);
    assign o_full       = i_q_full;
    assign o_cmd.bits   = bits;
    assign o_cmd.base_x = base_x;
    assign o_cmd.base_y = base_y;
    assign o_cmd.scale  = eff_scale;

endmodule

FILE: sv/bfr_cmdq.sv
// Two-entry command queue between front end and dot scanner.
module bfr_cmdq import bfr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [C_Q_DEPTH];
    logic [C_Q_AW-1:0] r_wp;
    logic [C_Q_AW-1:0] r_rp;
    logic [C_Q_CW-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == C_Q_CW'(C_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/bfr_back.sv
// Back end: scans the glyph bitmap and emits one dot rectangle per set bit.
module bfr_back import bfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_cmd,
    output logic      o_q_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic                 r_busy;
    t_glyph               r_bits;
    t_coord               r_base_x;
    t_coord               r_base_y;
    logic [C_SCALE_W-1:0] r_scale;
    logic [C_COL_W-1:0]   r_col;
    logic [C_OFS_W-1:0]   r_dx;
    logic [C_OFS_W-1:0]   r_dy;
    logic                 r_ov;
    t_out_item            r_out;
    logic                 adv;
    logic                 rest_zero;
    logic                 emit;
    logic                 load;
    logic [C_OFS_W-1:0]   scale_ext;

    assign scale_ext = C_OFS_W'(r_scale);
    assign adv       = r_busy && (!r_ov || pop);
    assign rest_zero = (r_bits[C_GLYPH_BITS-2:0] == '0);
    assign emit      = adv && r_bits[C_GLYPH_BITS-1];
    assign load      = !i_q_empty && (!r_busy || (adv && rest_zero));
    assign o_q_pop   = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits   <= i_cmd.bits;
            r_base_x <= i_cmd.base_x;
            r_base_y <= i_cmd.base_y;
            r_scale  <= i_cmd.scale;
            r_col    <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
        end else if (adv) begin
            r_bits <= {r_bits[C_GLYPH_BITS-2:0], 1'b0};
            if (r_col == C_LAST_COL) begin
                r_col <= '0;
                r_dx  <= '0;
                r_dy  <= r_dy + scale_ext;
            end else begin
                r_col <= r_col + 1'b1;
                r_dx  <= r_dx + scale_ext;
            end
        end
        if (emit) begin
            r_out.rect_x    <= add_ofs(r_base_x, r_dx);
            r_out.rect_y    <= add_ofs(r_base_y, r_dy);
            r_out.rect_size <= r_scale;
            r_out.last_dot  <= rest_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (adv && rest_zero) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign empty    = !r_ov;
    assign o_result = r_out;

endmodule

FILE: sv/bfr_chk.sv
// Port-level checker for the text rasterizer, bound to the top level.
module bfr_chk import bfr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      pop,
    input logic      empty,
    input t_out_item o_result
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result transaction changed");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.rect_size >= C_MIN_SCALE && o_result.rect_size <= C_MAX_SCALE))
        else $error("rectangle size out of range");

    a_same_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_result.last_dot) |=>
            (empty || o_result.rect_size == $past(o_result.rect_size)))
        else $error("rectangle size changed within a character");

endmodule

bind bitmap_font_text_rasterizer bfr_chk u_bfr_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
